FILE: hdl/sfw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfw_pkg
// Shared types and constants of the eye smoothing and fixation window block.
// ----------------------------------------------------------------------------
package sfw_pkg;

	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 33;
	localparam int CntW     = 17;
	localparam int RadW     = 33;

	localparam logic [CfgAddrW-1:0] REG_SMOOTH_LEN  = 3'd0;
	localparam logic [CfgAddrW-1:0] REG_CENTER_X    = 3'd1;
	localparam logic [CfgAddrW-1:0] REG_CENTER_Y    = 3'd2;
	localparam logic [CfgAddrW-1:0] REG_VSCALE      = 3'd3;
	localparam logic [CfgAddrW-1:0] REG_RADIUS_SQ   = 3'd4;
	localparam logic [CfgAddrW-1:0] REG_BREAK_LIMIT = 3'd5;
	localparam logic [CfgAddrW-1:0] REG_WIN_ACTIVE  = 3'd6;
	localparam logic [CfgAddrW-1:0] REG_INT_ENABLE  = 3'd7;

	localparam logic [15:0]     VSCALE_RESET = 16'd4096;
	localparam logic [CntW-1:0] CNT_MAX      = '1;

	typedef struct packed {
		logic [4:0]         smooth_len;
		logic signed [15:0] center_x;
		logic signed [15:0] center_y;
		logic [15:0]        vscale;
		logic [RadW-1:0]    radius_sq;
		logic [15:0]        break_limit;
		logic               win_active;
		logic               int_enable;
	} cfg_t;

	typedef struct packed {
		logic upd;
		logic rearm;
	} item_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/sfw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: hdl/sfw_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfw_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfw_div #(
	parameter int NUMW = 22,
	parameter int DENW = 6
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [NUMW-1:0] num,
	input  wire logic [DENW-1:0] den,
	output logic                 done,
	output logic      [NUMW-1:0] quot
);

	localparam int CW = $clog2(NUMW + 1);

	logic [DENW:0]   rem_q;
	logic [NUMW-1:0] quo_q;
	logic [DENW-1:0] den_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic [DENW+1:0] rem_sh;
	logic            fits;

	assign rem_sh = {rem_q, quo_q[NUMW-1]};
	assign fits   = rem_sh >= {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NUMW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? (DENW+1)'(rem_sh - {2'b00, den_q}) : rem_sh[DENW:0];
			quo_q <= {quo_q[NUMW-2:0], fits};
		end
	end

	assign done = !busy_q && !start;
	assign quot = quo_q;

endmodule
`default_nettype wire

FILE: hdl/sfw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfw_front
// Accepts eye samples, marks ring updates, and queues them for the back end.
// ----------------------------------------------------------------------------
module sfw_front #(
	parameter int P = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic signed [P-1:0]    in_x,
	input  wire logic signed [P-1:0]    in_y,
	input  wire logic [31:0]            in_time,
	input  wire logic                   in_new,
	input  wire logic                   in_ok,
	input  wire logic                   in_rearm,
	output logic                        q_valid,
	input  wire logic                   q_pop,
	output logic signed [P-1:0]         q_x,
	output logic signed [P-1:0]         q_y,
	output logic [31:0]                 q_time,
	output sfw_pkg::item_ctl_t          q_ctl
);

	logic signed [P-1:0] x_q [2];
	logic signed [P-1:0] y_q [2];
	logic [31:0]         t_q [2];
	sfw_pkg::item_ctl_t  c_q [2];
	logic                wr_q, rd_q;
	logic [1:0]          cnt_q;
	logic                push;

	assign in_ready = cnt_q != 2'd2;
	assign push     = in_valid && in_ready;
	assign q_valid  = cnt_q != 2'd0;
	assign q_x      = x_q[rd_q];
	assign q_y      = y_q[rd_q];
	assign q_time   = t_q[rd_q];
	assign q_ctl    = c_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (q_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			x_q[wr_q]       <= in_x;
			y_q[wr_q]       <= in_y;
			t_q[wr_q]       <= in_time;
			c_q[wr_q].upd   <= in_new && in_ok;
			c_q[wr_q].rearm <= in_rearm;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/sfw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfw_back
// Sequencer that smooths one queued sample, tests the fixation window and
// updates the break state when the window is active, then holds the result
// for the output transfer.
module sfw_back #(
	parameter int RING_DEPTH = 16,
	parameter int P          = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sfw_pkg::cfg_t       cfg,
	input  wire logic                arm_we,
	input  wire logic                arm_val,
	input  wire logic                q_valid,
	output logic                     q_pop,
	input  wire logic signed [P-1:0] q_x,
	input  wire logic signed [P-1:0] q_y,
	input  wire logic [31:0]         q_time,
	input  wire sfw_pkg::item_ctl_t  q_ctl,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [P-1:0]      out_x,
	output logic signed [P-1:0]      out_y,
	output logic                     out_inside,
	output logic                     out_broken,
	output logic                     out_irq,
	output logic [31:0]              out_stamp
);

	localparam int AW   = $clog2(RING_DEPTH);
	localparam int LW   = $clog2(RING_DEPTH + 1);
	localparam int SW   = P + AW;
	localparam int NUMW = SW + 2;
	localparam int DENW = LW + 1;
	localparam int DW   = ((P > 16) ? P : 16) + 1;
	localparam int MW   = 2 * DW;
	localparam int CW   = (MW > sfw_pkg::RadW) ? MW : sfw_pkg::RadW;
	localparam int TW   = sfw_pkg::RadW + 24;
	localparam int YW   = DW + 16;
	localparam logic [NUMW-1:0] HALF = NUMW'(1) << (P - 1);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_RD   = 10'b0000000010,
		ST_UPD  = 10'b0000000100,
		ST_DST  = 10'b0000001000,
		ST_DIV  = 10'b0000010000,
		ST_WIN  = 10'b0000100000,
		ST_MUL  = 10'b0001000000,
		ST_SQ   = 10'b0010000000,
		ST_CMP  = 10'b0100000000,
		ST_OUT  = 10'b1000000000
	} state_t;

	state_t                 state_q;
	logic signed [P-1:0]    x_q, y_q, sx_q, sy_q, mean_x_q, mean_y_q;
	logic [31:0]            time_q, stamp_q;
	sfw_pkg::item_ctl_t     ctl_q;
	logic signed [SW-1:0]   sum_x_q, sum_y_q;
	logic [LW-1:0]          pos_q, n;
	logic [RING_DEPTH-1:0]  vld_q;
	logic                   inside_q, timing_q, broke_q, armed_q, irq_q;
	logic [sfw_pkg::CntW-1:0] cnt_q, cnt_base, cnt_inc;
	logic [DW-1:0]          adx_q, ady_q;
	logic [MW-1:0]          dx2_q;
	logic [YW-1:0]          dyq_q;
	logic                   ok_q;
	logic [TW-1:0]          t_q;
	logic [57:0]            sq_q;
	logic [2*P-1:0]         rdata;
	logic signed [P-1:0]    old_x, old_y;
	logic [SW-1:0]          mag_x, mag_y;
	logic                   div_start, done_x, done_y;
	logic [NUMW-1:0]        quo_x, quo_y;
	logic signed [P-1:0]    sat_x, sat_y;
	logic signed [DW-1:0]   dx, dy;
	logic [CW-1:0]          dx2_ext, rad_ext;
	logic                   in_w, tim_n;

	assign n = (32'(cfg.smooth_len) > RING_DEPTH) ? LW'(RING_DEPTH) : LW'(cfg.smooth_len);

	sfw_ram #(.WIDTH(2 * P), .DEPTH(RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (state_q == ST_UPD),
		.waddr (pos_q[AW-1:0]),
		.wdata ({y_q, x_q}),
		.raddr (pos_q[AW-1:0]),
		.rdata (rdata)
	);

	assign old_x = vld_q[pos_q[AW-1:0]] ? $signed(rdata[P-1:0]) : '0;
	assign old_y = vld_q[pos_q[AW-1:0]] ? $signed(rdata[2*P-1:P]) : '0;

	assign mag_x     = sum_x_q[SW-1] ? SW'(-sum_x_q) : SW'(sum_x_q);
	assign mag_y     = sum_y_q[SW-1] ? SW'(-sum_y_q) : SW'(sum_y_q);
	assign div_start = state_q == ST_DST;

	sfw_div #(.NUMW(NUMW), .DENW(DENW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({1'b0, mag_x, 1'b0} + NUMW'(n)), .den({n, 1'b0}),
		.done(done_x), .quot(quo_x)
	);

	sfw_div #(.NUMW(NUMW), .DENW(DENW)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({1'b0, mag_y, 1'b0} + NUMW'(n)), .den({n, 1'b0}),
		.done(done_y), .quot(quo_y)
	);

	always_comb begin
		if (sum_x_q[SW-1]) begin
			sat_x = (quo_x > HALF) ? P'(HALF) : P'(-quo_x);
		end else begin
			sat_x = (quo_x > HALF - 1'b1) ? P'(HALF - 1'b1) : P'(quo_x);
		end
		if (sum_y_q[SW-1]) begin
			sat_y = (quo_y > HALF) ? P'(HALF) : P'(-quo_y);
		end else begin
			sat_y = (quo_y > HALF - 1'b1) ? P'(HALF - 1'b1) : P'(quo_y);
		end
	end

	assign dx      = DW'(sx_q) - DW'(cfg.center_x);
	assign dy      = DW'(sy_q) - DW'(cfg.center_y);
	assign dx2_ext = CW'(dx2_q);
	assign rad_ext = CW'(cfg.radius_sq);
	assign in_w    = ok_q && (58'(t_q) > sq_q);
	assign tim_n   = timing_q || inside_q;
	assign cnt_base = inside_q ? '0 : cnt_q;
	assign cnt_inc  = (cnt_base < sfw_pkg::CNT_MAX) ? cnt_base + 1'b1 : cnt_base;
	assign q_pop    = (state_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			pos_q     <= '0;
			vld_q     <= '0;
			mean_x_q  <= '0;
			mean_y_q  <= '0;
			inside_q  <= 1'b0;
			timing_q  <= 1'b0;
			cnt_q     <= '0;
			broke_q   <= 1'b0;
			stamp_q   <= '0;
			armed_q   <= 1'b0;
			irq_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != ST_OUT) begin
				out_valid <= 1'b0;
			end
			if (arm_we) begin
				armed_q <= arm_val;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					irq_q <= 1'b0;
					if (ctl_q.rearm) begin
						broke_q <= 1'b0;
						armed_q <= cfg.int_enable;
					end
					if (n > LW'(1)) begin
						state_q <= ctl_q.upd ? ST_UPD : ST_WIN;
					end else begin
						state_q <= ST_WIN;
					end
				end
				ST_UPD: begin
					sum_x_q <= sum_x_q + SW'(x_q) - SW'(old_x);
					sum_y_q <= sum_y_q + SW'(y_q) - SW'(old_y);
					vld_q[pos_q[AW-1:0]] <= 1'b1;
					pos_q   <= pos_q + 1'b1;
					state_q <= ST_DST;
				end
				ST_DST: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (pos_q >= n) begin
						pos_q <= pos_q - n;
					end else if (done_x && done_y) begin
						mean_x_q <= sat_x;
						mean_y_q <= sat_y;
						state_q  <= ST_WIN;
					end
				end
				ST_WIN: begin
					state_q <= cfg.win_active ? ST_MUL : ST_OUT;
				end
				ST_MUL: begin
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (in_w) begin
						inside_q <= 1'b1;
						timing_q <= 1'b0;
					end else begin
						inside_q <= 1'b0;
						timing_q <= tim_n;
						cnt_q    <= tim_n ? cnt_inc : cnt_base;
						if (tim_n && cnt_inc > 17'(cfg.break_limit)) begin
							if (!broke_q) begin
								stamp_q <= time_q;
							end
							broke_q <= 1'b1;
							if (armed_q) begin
								irq_q   <= 1'b1;
								armed_q <= 1'b0;
							end
						end
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			x_q    <= q_x;
			y_q    <= q_y;
			time_q <= q_time;
			ctl_q  <= q_ctl;
		end
		if (state_q == ST_RD) begin
			sx_q <= (n > LW'(1)) ? mean_x_q : x_q;
			sy_q <= (n > LW'(1)) ? mean_y_q : y_q;
		end
		if (state_q == ST_DIV) begin
			sx_q <= sat_x;
			sy_q <= sat_y;
		end
		if (state_q == ST_WIN) begin
			adx_q <= dx[DW-1] ? DW'(-dx) : DW'(dx);
			ady_q <= dy[DW-1] ? DW'(-dy) : DW'(dy);
		end
		if (state_q == ST_MUL) begin
			dx2_q <= adx_q * adx_q;
			dyq_q <= YW'(ady_q) * YW'(cfg.vscale);
		end
		if (state_q == ST_SQ) begin
			ok_q <= (dx2_ext < rad_ext) && ((dyq_q >> 29) == '0);
			t_q  <= TW'(sfw_pkg::RadW'(rad_ext - dx2_ext)) << 24;
			sq_q <= 58'(dyq_q[28:0]) * 58'(dyq_q[28:0]);
		end
		if (state_q == ST_OUT && (!out_valid || out_ready)) begin
			out_x      <= sx_q;
			out_y      <= sy_q;
			out_inside <= inside_q;
			out_broken <= broke_q;
			out_irq    <= irq_q;
			out_stamp  <= stamp_q;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/eye_smooth_fixation_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eye_smooth_fixation_window
// Eye position smoother with one elliptical fixation window and break detection.
// ----------------------------------------------------------------------------
// From the queue an item passes ST_RD, ST_WIN and ST_OUT, with ST_MUL, ST_SQ and
// ST_CMP before ST_OUT when the window is on; a ring update adds ST_UPD, ST_DST
// and the bit-serial divider for the rounded mean in ST_DIV. The ring position
// wrap after a shortened smoothing length overlaps the divider. One item is
// worked at a time; the next leaves the queue once the result is registered.
// Reset clears the ring valid bits, sums, window state and configuration.
module eye_smooth_fixation_window #(
	parameter int RING_DEPTH = 16,
	parameter int POS_BITS   = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// eye_x, eye_y, time_ms, rearm, zero fill
	input  wire logic [((2*POS_BITS+33+7)/8)*8-1:0] s_axis_tdata,
	// sample_new, sample_valid
	input  wire logic [1:0]                     s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// smooth_x, smooth_y, is_inside, has_broken, break_irq, break_stamp, zero fill
	output logic [((2*POS_BITS+35+7)/8)*8-1:0]  m_axis_tdata,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [sfw_pkg::CfgAddrW-1:0]   cfg_addr,
	input  wire logic [sfw_pkg::CfgDataW-1:0]   cfg_data
);

	localparam int P     = POS_BITS;
	localparam int OUT_W = ((2 * P + 35 + 7) / 8) * 8;

	sfw_pkg::cfg_t      cfg_q;
	logic               cfg_we;
	logic               q_valid, q_pop;
	logic signed [P-1:0] q_x, q_y;
	logic [31:0]        q_time;
	sfw_pkg::item_ctl_t q_ctl;
	logic signed [P-1:0] o_x, o_y;
	logic               o_in, o_brk, o_irq;
	logic [31:0]        o_stamp;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{smooth_len: '0, center_x: '0, center_y: '0,
				vscale: sfw_pkg::VSCALE_RESET, radius_sq: '0, break_limit: '0,
				win_active: 1'b0, int_enable: 1'b0};
		end else if (cfg_we) begin
			case (cfg_addr)
				sfw_pkg::REG_SMOOTH_LEN:  cfg_q.smooth_len  <= cfg_data[4:0];
				sfw_pkg::REG_CENTER_X:    cfg_q.center_x    <= $signed(cfg_data[15:0]);
				sfw_pkg::REG_CENTER_Y:    cfg_q.center_y    <= $signed(cfg_data[15:0]);
				sfw_pkg::REG_VSCALE:      cfg_q.vscale      <= cfg_data[15:0];
				sfw_pkg::REG_RADIUS_SQ:   cfg_q.radius_sq   <= cfg_data[32:0];
				sfw_pkg::REG_BREAK_LIMIT: cfg_q.break_limit <= cfg_data[15:0];
				sfw_pkg::REG_WIN_ACTIVE:  cfg_q.win_active  <= cfg_data[0];
				sfw_pkg::REG_INT_ENABLE:  cfg_q.int_enable  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	sfw_front #(.P(P)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_x     ($signed(s_axis_tdata[P-1:0])),
		.in_y     ($signed(s_axis_tdata[2*P-1:P])),
		.in_time  (s_axis_tdata[2*P+31:2*P]),
		.in_new   (s_axis_tuser[0]),
		.in_ok    (s_axis_tuser[1]),
		.in_rearm (s_axis_tdata[2*P+32]),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_x      (q_x),
		.q_y      (q_y),
		.q_time   (q_time),
		.q_ctl    (q_ctl)
	);

	sfw_back #(.RING_DEPTH(RING_DEPTH), .P(P)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.arm_we     (cfg_we && cfg_addr == sfw_pkg::REG_INT_ENABLE),
		.arm_val    (cfg_data[0]),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_x        (q_x),
		.q_y        (q_y),
		.q_time     (q_time),
		.q_ctl      (q_ctl),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_x      (o_x),
		.out_y      (o_y),
		.out_inside (o_in),
		.out_broken (o_brk),
		.out_irq    (o_irq),
		.out_stamp  (o_stamp)
	);

	assign m_axis_tdata = OUT_W'({o_stamp, o_irq, o_brk, o_in, o_y, o_x});

endmodule
`default_nettype wire

FILE: hdl/sfw_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfw_checker
// Port-level checks of the eye smoothing and fixation window block.
// ----------------------------------------------------------------------------
module sfw_checker #(
	parameter int POS_BITS = 16
) (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  m_axis_tvalid,
	input wire logic                                  m_axis_tready,
	input wire logic [((2*POS_BITS+35+7)/8)*8-1:0]    m_axis_tdata
);

	localparam int P = POS_BITS;

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2*P+2] |-> m_axis_tdata[2*P+1])
		else $error("interrupt without break flag");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2*P+2] |-> !m_axis_tdata[2*P])
		else $error("interrupt while inside the window");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result transfer changed");

endmodule

bind eye_smooth_fixation_window sfw_checker #(.POS_BITS(POS_BITS)) u_sfw_checker (.*);
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the eye smoother and fixation window. A directed
// table and six random phases drive samples over the input stream with
// random gaps; every output transfer is compared field by field against an
// in-bench predictor that tracks the ring, the window and the break logic.
// ----------------------------------------------------------------------------
module testbench;

	localparam int PW = 16;
	localparam int DW = ((2*PW+33+7)/8)*8;
	localparam int OW = ((2*PW+35+7)/8)*8;

	typedef struct packed {
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic               in_win;
		logic               broken;
		logic               irq;
		logic [31:0]        stamp;
	} gaze_t;

	typedef struct {
		logic signed [15:0] ex;
		logic signed [15:0] ey;
		logic               fresh;
		logic               good;
		logic [31:0]        ms;
		logic               rearm;
		logic               known;
		gaze_t              res;
	} row_t;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [DW-1:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid, m_axis_tready;
	logic [OW-1:0] m_axis_tdata;
	logic cfg_valid, cfg_ready;
	logic [sfw_pkg::CfgAddrW-1:0] cfg_addr;
	logic [sfw_pkg::CfgDataW-1:0] cfg_data;

	eye_smooth_fixation_window dut (.*);

	// predictor state
	logic [4:0] p_len;
	logic signed [15:0] p_cx, p_cy;
	logic [15:0] p_vs, p_blim;
	logic [32:0] p_rad;
	logic p_act, p_ien;
	longint ring_x[16], ring_y[16];
	longint sum_x, sum_y, mean_x, mean_y;
	int unsigned ring_pos, out_cnt;
	logic in_flag, timing, broke, armed;
	logic [31:0] brk_time;

	gaze_t pending_gaze[$];
	int errors = 0;
	bit hold_rx = 0;
	int ms_clock = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("eye_smooth_fixation_window test failed");
		$finish;
	end

	function automatic longint mean_of(longint s, int unsigned n);
		longint unsigned mag, q;
		mag = (s < 0) ? -s : s;
		q = (2*mag + n) / (2*n);
		if (s < 0) return (q > 32768) ? -32768 : -longint'(q);
		return (q > 32767) ? 32767 : longint'(q);
	endfunction

	function automatic bit within_window(longint px, longint py);
		longint unsigned adx, ady, dx2, t, dyq;
		adx = (px - p_cx < 0) ? p_cx - px : px - p_cx;
		ady = (py - p_cy < 0) ? p_cy - py : py - p_cy;
		if (adx > 92682) return 0;
		dx2 = adx * adx;
		if (dx2 >= p_rad) return 0;
		t = (p_rad - dx2) << 24;
		dyq = ady * p_vs;
		if (dyq >= (64'd1 << 29)) return 0;
		return dyq * dyq < t;
	endfunction

	task automatic predict_reset();
		for (int i = 0; i < 16; i++) begin
			ring_x[i] = 0;
			ring_y[i] = 0;
		end
		sum_x = 0; sum_y = 0; ring_pos = 0; mean_x = 0; mean_y = 0;
		in_flag = 0; timing = 0; broke = 0; armed = 0; out_cnt = 0; brk_time = 0;
		p_len = 0; p_cx = 0; p_cy = 0; p_vs = sfw_pkg::VSCALE_RESET; p_rad = 0;
		p_blim = 0; p_act = 0; p_ien = 0;
	endtask

	function automatic gaze_t predict_gaze(row_t r);
		gaze_t g;
		int unsigned n, p;
		longint sx, sy;
		g.irq = 0;
		if (r.rearm) begin
			broke = 0;
			armed = p_ien;
		end
		n = (p_len > 16) ? 16 : p_len;
		if (n > 1) begin
			if (r.fresh && r.good) begin
				p = ring_pos % 16;
				sum_x += r.ex - ring_x[p];
				sum_y += r.ey - ring_y[p];
				ring_x[p] = r.ex;
				ring_y[p] = r.ey;
				ring_pos = (p + 1) % n;
				mean_x = mean_of(sum_x, n);
				mean_y = mean_of(sum_y, n);
			end
			sx = mean_x;
			sy = mean_y;
		end else begin
			sx = r.ex;
			sy = r.ey;
		end
		if (p_act) begin
			if (within_window(sx, sy)) begin
				in_flag = 1;
				timing = 0;
			end else begin
				if (in_flag) begin
					timing = 1;
					out_cnt = 0;
				end
				in_flag = 0;
				if (timing) begin
					if (out_cnt < 131071) out_cnt++;
					if (out_cnt > p_blim) begin
						if (!broke) brk_time = r.ms;
						broke = 1;
						if (armed) begin
							g.irq = 1;
							armed = 0;
						end
					end
				end
			end
		end
		g.sx = sx[15:0];
		g.sy = sy[15:0];
		g.in_win = in_flag;
		g.broken = broke;
		g.stamp = brk_time;
		return g;
	endfunction

	task automatic write_reg(logic [sfw_pkg::CfgAddrW-1:0] idx, longint unsigned val);
		cfg_valid <= 1;
		cfg_addr <= idx;
		cfg_data <= val[sfw_pkg::CfgDataW-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		case (idx)
			sfw_pkg::REG_SMOOTH_LEN:  p_len = val[4:0];
			sfw_pkg::REG_CENTER_X:    p_cx = val[15:0];
			sfw_pkg::REG_CENTER_Y:    p_cy = val[15:0];
			sfw_pkg::REG_VSCALE:      p_vs = val[15:0];
			sfw_pkg::REG_RADIUS_SQ:   p_rad = val[32:0];
			sfw_pkg::REG_BREAK_LIMIT: p_blim = val[15:0];
			sfw_pkg::REG_WIN_ACTIVE:  p_act = val[0];
			sfw_pkg::REG_INT_ENABLE: begin
				p_ien = val[0];
				armed = val[0];
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (pending_gaze.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send_sample(row_t r);
		gaze_t g;
		int gap;
		s_axis_tvalid <= 1;
		s_axis_tdata <= {{(DW-65){1'b0}}, r.rearm, r.ms, r.ey, r.ex};
		s_axis_tuser <= {r.good, r.fresh};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		g = predict_gaze(r);
		if (r.known && g != r.res) begin
			$error("table row mismatch: expected %h actual predictor %h", r.res, g);
			errors++;
		end
		pending_gaze.push_back(g);
		gap = $urandom_range(0, 13);
		if (gap != 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic row_t rand_row(int spread);
		row_t r;
		int cx, cy;
		cx = p_cx;
		cy = p_cy;
		ms_clock += $urandom_range(1, 3);
		if ($urandom_range(0, 9) == 0) begin
			r.ex = 16'($urandom);
			r.ey = 16'($urandom);
		end else begin
			r.ex = 16'(cx + $signed($urandom_range(0, 2*spread)) - spread);
			r.ey = 16'(cy + $signed($urandom_range(0, 2*spread)) - spread);
		end
		r.fresh = $urandom_range(0, 7) != 0;
		r.good = $urandom_range(0, 7) != 0;
		r.ms = ($urandom_range(0, 20) == 0) ? $urandom : ms_clock;
		r.rearm = $urandom_range(0, 24) == 0;
		r.known = 0;
		return r;
	endfunction

	function automatic row_t mk(int x, int y, bit f, bit v, int unsigned ms, bit ra);
		row_t r;
		r.ex = 16'(x); r.ey = 16'(y); r.fresh = f; r.good = v; r.ms = ms; r.rearm = ra;
		r.known = 0;
		return r;
	endfunction

	function automatic row_t mkk(int x, int y, bit f, bit v, int unsigned ms, bit ra,
			gaze_t g);
		row_t r;
		r = mk(x, y, f, v, ms, ra);
		r.known = 1;
		r.res = g;
		return r;
	endfunction

	// receiver: random stalls plus one long hold-off on request
	initial begin
		m_axis_tready = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				m_axis_tready <= 0;
				repeat (400) @(posedge clk);
				hold_rx = 0;
			end else if (m_axis_tready && m_axis_tvalid) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(0, 13)) @(posedge clk);
				m_axis_tready <= 1;
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		gaze_t exp_g, act;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			act.sx = m_axis_tdata[15:0];
			act.sy = m_axis_tdata[31:16];
			act.in_win = m_axis_tdata[32];
			act.broken = m_axis_tdata[33];
			act.irq = m_axis_tdata[34];
			act.stamp = m_axis_tdata[66:35];
			if (pending_gaze.size() == 0) begin
				$error("output transfer with nothing expected: %h", m_axis_tdata);
				errors++;
			end else begin
				exp_g = pending_gaze.pop_front();
				if (act.sx !== exp_g.sx) begin
					$error("smooth_x expected %0d actual %0d", exp_g.sx, act.sx);
					errors++;
				end
				if (act.sy !== exp_g.sy) begin
					$error("smooth_y expected %0d actual %0d", exp_g.sy, act.sy);
					errors++;
				end
				if (act.in_win !== exp_g.in_win) begin
					$error("is_inside expected %b actual %b", exp_g.in_win, act.in_win);
					errors++;
				end
				if (act.broken !== exp_g.broken) begin
					$error("has_broken expected %b actual %b", exp_g.broken, act.broken);
					errors++;
				end
				if (act.irq !== exp_g.irq) begin
					$error("break_irq expected %b actual %b", exp_g.irq, act.irq);
					errors++;
				end
				if (act.stamp !== exp_g.stamp) begin
					$error("break_stamp expected %0d actual %0d", exp_g.stamp, act.stamp);
					errors++;
				end
			end
		end
	end

	initial begin
		row_t dir_rows[$];
		row_t r;
		int phase_len[6] = '{0, 1, 4, 16, 31, 3};
		longint unsigned rad;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 0;
		cfg_addr = '0;
		cfg_data = '0;
		predict_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		// after reset: passthrough, window off
		dir_rows.push_back(mkk(32767, -32768, 1, 1, 5, 0, '{32767, -32768, 0, 0, 0, 0}));
		dir_rows.push_back(mkk(-32768, 32767, 0, 0, 6, 1, '{-32768, 32767, 0, 0, 0, 0}));
		dir_rows.push_back(mkk(0, 0, 1, 0, 32'hFFFF_FFFF, 0, '{0, 0, 0, 0, 0, 0}));
		foreach (dir_rows[i]) send_sample(dir_rows[i]);
		drain();

		// smoothing over extremes, window with break and irq
		write_reg(sfw_pkg::REG_SMOOTH_LEN, 2);
		write_reg(sfw_pkg::REG_CENTER_X, 0);
		write_reg(sfw_pkg::REG_CENTER_Y, 0);
		write_reg(sfw_pkg::REG_VSCALE, 0);
		write_reg(sfw_pkg::REG_RADIUS_SQ, 100);
		write_reg(sfw_pkg::REG_BREAK_LIMIT, 1);
		write_reg(sfw_pkg::REG_WIN_ACTIVE, 1);
		write_reg(sfw_pkg::REG_INT_ENABLE, 1);
		dir_rows = {};
		dir_rows.push_back(mk(32767, 32767, 1, 1, 10, 0));
		dir_rows.push_back(mk(32767, 32767, 1, 1, 11, 0));
		dir_rows.push_back(mk(-32768, -32768, 1, 1, 12, 0));
		dir_rows.push_back(mk(-32768, -32768, 1, 1, 13, 0));
		dir_rows.push_back(mk(1, 1, 1, 1, 14, 0));
		dir_rows.push_back(mk(2, 500, 1, 1, 15, 0));
		dir_rows.push_back(mk(3, 3, 0, 1, 16, 0));
		dir_rows.push_back(mk(50, 3, 1, 1, 17, 0));
		dir_rows.push_back(mk(50, 3, 1, 0, 18, 0));
		dir_rows.push_back(mk(50, 3, 1, 1, 19, 0));
		dir_rows.push_back(mk(50, 3, 1, 1, 20, 0));
		dir_rows.push_back(mk(50, 3, 1, 1, 21, 1));
		dir_rows.push_back(mk(50, 3, 1, 1, 22, 0));
		foreach (dir_rows[i]) send_sample(dir_rows[i]);
		drain();
		write_reg(sfw_pkg::REG_VSCALE, 16'hFFFF);
		write_reg(sfw_pkg::REG_RADIUS_SQ, 33'h1_FFFF_FFFF);
		write_reg(sfw_pkg::REG_BREAK_LIMIT, 0);
		write_reg(sfw_pkg::REG_CENTER_X, -32768);
		write_reg(sfw_pkg::REG_CENTER_Y, 32767);
		send_sample(mk(32767, -32768, 1, 1, 30, 0));
		send_sample(mk(-32768, 32767, 1, 1, 31, 0));
		send_sample(mk(-32768, 32767, 1, 1, 32, 0));
		send_sample(mk(0, 0, 1, 1, 33, 0));
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(sfw_pkg::REG_SMOOTH_LEN, phase_len[ph]);
			write_reg(sfw_pkg::REG_CENTER_X,
				(ph == 5) ? 32767 : $urandom_range(0, 2000) - 1000);
			write_reg(sfw_pkg::REG_CENTER_Y,
				(ph == 5) ? -32768 : $urandom_range(0, 2000) - 1000);
			write_reg(sfw_pkg::REG_VSCALE, (ph == 2) ? 1 : $urandom_range(2048, 8192));
			rad = (ph == 4) ? 0 : $urandom_range(400, 90000);
			write_reg(sfw_pkg::REG_RADIUS_SQ, rad);
			write_reg(sfw_pkg::REG_BREAK_LIMIT, (ph == 3) ? 16'hFFFF : $urandom_range(0, 8));
			write_reg(sfw_pkg::REG_WIN_ACTIVE, ph != 1);
			write_reg(sfw_pkg::REG_INT_ENABLE, $urandom_range(0, 1));
			for (int i = 0; i < 250; i++) begin
				if (ph == 2 && i == 40) hold_rx = 1;
				r = rand_row((i % 60 < 30) ? 150 : 600);
				send_sample(r);
				if (ph == 3 && i == 100) drain();
			end
			drain();
		end
		if (errors == 0) begin
			$display("eye_smooth_fixation_window test passed");
		end else begin
			$display("eye_smooth_fixation_window test failed");
		end
		$finish;
	end
endmodule

FILE: eye_smooth_fixation_window.f
hdl/sfw_pkg.sv
hdl/sfw_ram.sv
hdl/sfw_div.sv
hdl/sfw_front.sv
hdl/sfw_back.sv
hdl/eye_smooth_fixation_window.sv
hdl/sfw_checker.sv
tb/testbench.sv
